// ----- hw/rtl/rtca_pkg.sv -----
// Package: shared widths, register indexes, reset values and control structs.
`timescale 1ns / 1ps
package rtca_pkg;

  localparam int PIX_W            = 8;
  localparam int XW               = 9;
  localparam int YW               = 8;
  localparam int SUM_W            = 25;
  localparam int CNT_W            = 17;
  localparam int Q_W              = 8;
  localparam int NUM_CH           = 3;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 9;
  localparam int DIV_CNT_W        = 3;
  localparam int DEFAULT_FRAME_WIDTH = 320;

  localparam logic [XW-1:0]    RST_X_LOW     = 9'd128;
  localparam logic [XW-1:0]    RST_X_HIGH    = 9'd192;
  localparam logic [YW-1:0]    RST_Y_LOW     = 8'd96;
  localparam logic [YW-1:0]    RST_Y_HIGH    = 8'd144;
  localparam logic [PIX_W-1:0] RST_THRESHOLD = 8'd42;
  localparam logic [PIX_W-1:0] PIX_WHITE     = 8'd255;
  localparam logic [YW-1:0]    ROW_MAX       = 8'd255;
  localparam logic [CNT_W-1:0] CNT_MAX       = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_LOW     = 3'd0,
    CFG_X_HIGH    = 3'd1,
    CFG_Y_LOW     = 3'd2,
    CFG_Y_HIGH    = 3'd3,
    CFG_THRESHOLD = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic pixel_step;
    logic last_take;
    logic div_init;
    logic div_step;
    logic div_done;
  } rtca_cmd_t;

  typedef struct packed {
    logic last;
  } rtca_status_t;

endpackage

// ----- hw/rtl/rtca_pixel_if.sv -----
// Interface: input pixel channel.
`timescale 1ns / 1ps
interface rtca_pixel_if
  import rtca_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_red;
  logic [PIX_W-1:0] pixel_green;
  logic [PIX_W-1:0] pixel_blue;
  logic             last_pixel;

  modport source (output valid, pixel_red, pixel_green, pixel_blue, last_pixel,
                  input ready);
  modport sink (input valid, pixel_red, pixel_green, pixel_blue, last_pixel,
                output ready);
endinterface

// ----- hw/rtl/rtca_result_if.sv -----
// Interface: result channel with passed pixel and frame averages.
`timescale 1ns / 1ps
interface rtca_result_if
  import rtca_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] out_red;
  logic [PIX_W-1:0] out_green;
  logic [PIX_W-1:0] out_blue;
  logic             averages_valid;
  logic [PIX_W-1:0] average_red;
  logic [PIX_W-1:0] average_green;
  logic [PIX_W-1:0] average_blue;

  modport source (output valid, out_red, out_green, out_blue, averages_valid,
                  average_red, average_green, average_blue, input ready);
  modport sink (input valid, out_red, out_green, out_blue, averages_valid,
                average_red, average_green, average_blue, output ready);
endinterface

// ----- hw/rtl/rtca_cfg_if.sv -----
// Interface: configuration write channel.
`timescale 1ns / 1ps
interface rtca_cfg_if
  import rtca_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/rtca_ctrl.sv -----
// Controller: item handshake, output slot and frame-end division sequencing.
`timescale 1ns / 1ps
module rtca_ctrl
  import rtca_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  input  rtca_status_t status,
  output rtca_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_RUN  = 4'b0001,
    S_INIT = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t               state, state_next;
  logic [DIV_CNT_W-1:0] div_cnt, div_cnt_next;
  logic                 out_valid_next;
  logic                 in_acc;

  assign in_ready = (state == S_RUN) && (!out_valid || out_ready);
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    state_next     = state;
    div_cnt_next   = div_cnt;
    out_valid_next = out_valid && !out_ready;
    cmd            = '0;
    unique case (state)
      S_RUN: begin
        if (in_acc) begin
          if (status.last) begin
            cmd.last_take = 1'b1;
            state_next    = S_INIT;
          end else begin
            cmd.pixel_step = 1'b1;
            out_valid_next = 1'b1;
          end
        end
      end
      S_INIT: begin
        cmd.div_init = 1'b1;
        div_cnt_next = '0;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_next = div_cnt + 1'b1;
        if (div_cnt == '1) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        cmd.div_done   = 1'b1;
        out_valid_next = 1'b1;
        state_next     = S_RUN;
      end
      default: begin
        state_next = S_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_RUN;
      div_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      div_cnt   <= div_cnt_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_RUN) |-> !in_ready)
    else $error("item taken while dividing");
  a_last_starts_div: assert property (@(posedge clk) disable iff (rst)
    (in_acc && status.last) |=> (state == S_INIT))
    else $error("last item did not start division");
  a_div_length: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && div_cnt == '1) |=> (state == S_DONE))
    else $error("division step count wrong");
  a_done_shows_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |=> out_valid)
    else $error("frame result not presented");
  a_no_result_while_div: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> !out_valid)
    else $error("result slot busy during division");
`endif

endmodule

// ----- hw/rtl/rtca_datapath.sv -----
// Datapath: config registers, raster position, sums, divider and output register.
`timescale 1ns / 1ps
module rtca_datapath
  import rtca_pkg::*;
#(
  parameter int FRAME_WIDTH = DEFAULT_FRAME_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [PIX_W-1:0]      pixel_red,
  input  logic [PIX_W-1:0]      pixel_green,
  input  logic [PIX_W-1:0]      pixel_blue,
  input  logic                  last_pixel,
  input  rtca_cmd_t             cmd,
  output rtca_status_t          status,
  output logic [PIX_W-1:0]      out_red,
  output logic [PIX_W-1:0]      out_green,
  output logic [PIX_W-1:0]      out_blue,
  output logic                  averages_valid,
  output logic [PIX_W-1:0]      average_red,
  output logic [PIX_W-1:0]      average_green,
  output logic [PIX_W-1:0]      average_blue
);

  localparam int COL_W = $clog2(FRAME_WIDTH);
  localparam int CMP_W = (COL_W > XW) ? COL_W : XW;
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(FRAME_WIDTH - 1);

  logic [XW-1:0]    x_low, x_high;
  logic [YW-1:0]    y_low, y_high;
  logic [PIX_W-1:0] threshold;

  logic [COL_W-1:0] col;
  logic [YW-1:0]    row;

  logic [NUM_CH-1:0][PIX_W-1:0] pix;
  logic [NUM_CH-1:0][SUM_W-1:0] sum;
  logic [NUM_CH-1:0][SUM_W-1:0] rem;
  logic [NUM_CH-1:0][Q_W-1:0]   quo;
  logic [NUM_CH-1:0]            ovf;
  logic [SUM_W-1:0]             dsh;
  logic [CNT_W-1:0]             count;

  logic [NUM_CH-1:0][SUM_W-1:0] sum_add;
  logic [NUM_CH-1:0][SUM_W:0]   sum_wide;
  logic [NUM_CH-1:0]            rem_ge;
  logic [NUM_CH-1:0][PIX_W-1:0] avg;
  logic                         in_window, bright, sample;
  logic [CMP_W-1:0]             col_e;

  assign pix[0] = pixel_red;
  assign pix[1] = pixel_green;
  assign pix[2] = pixel_blue;
  assign status.last = last_pixel;

  assign col_e     = CMP_W'(col);
  assign in_window = (col_e > CMP_W'(x_low)) && (col_e < CMP_W'(x_high))
                  && (row > y_low) && (row < y_high);
  assign bright = (pixel_red > threshold) || (pixel_green > threshold)
               || (pixel_blue > threshold);
  assign sample = in_window && bright;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      sum_wide[c] = {1'b0, sum[c]} + (SUM_W + 1)'(pix[c]);
      sum_add[c]  = sum_wide[c][SUM_W] ? '1 : sum_wide[c][SUM_W-1:0];
      rem_ge[c]   = rem[c] >= dsh;
      avg[c]      = ovf[c] ? PIX_WHITE : quo[c];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_low     <= RST_X_LOW;
      x_high    <= RST_X_HIGH;
      y_low     <= RST_Y_LOW;
      y_high    <= RST_Y_HIGH;
      threshold <= RST_THRESHOLD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_X_LOW:     x_low     <= cfg_data;
        CFG_X_HIGH:    x_high    <= cfg_data;
        CFG_Y_LOW:     y_low     <= cfg_data[YW-1:0];
        CFG_Y_HIGH:    y_high    <= cfg_data[YW-1:0];
        CFG_THRESHOLD: threshold <= cfg_data[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col   <= '0;
      row   <= '0;
      sum   <= '0;
      count <= CNT_W'(1);
    end else begin
      if (cmd.pixel_step || cmd.last_take) begin
        if (sample) begin
          sum   <= sum_add;
          count <= (count == CNT_MAX) ? CNT_MAX : count + 1'b1;
        end
      end
      if (cmd.pixel_step) begin
        if (col == COL_LAST) begin
          col <= '0;
          if (row != ROW_MAX) begin
            row <= row + 1'b1;
          end
        end else begin
          col <= col + 1'b1;
        end
      end
      if (cmd.last_take) begin
        col <= '0;
        row <= '0;
      end
      if (cmd.div_done) begin
        sum   <= '0;
        count <= CNT_W'(1);
      end
    end
  end

  // restoring division, one quotient bit per step; quotient above 255 clamps
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem <= sum;
      quo <= '0;
      dsh <= {1'b0, count, 7'b0};
      for (int c = 0; c < NUM_CH; c++) begin
        ovf[c] <= sum[c] >= {count, 8'b0};
      end
    end else if (cmd.div_step) begin
      dsh <= dsh >> 1;
      for (int c = 0; c < NUM_CH; c++) begin
        rem[c] <= rem_ge[c] ? rem[c] - dsh : rem[c];
        quo[c] <= {quo[c][Q_W-2:0], rem_ge[c]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pixel_step || cmd.last_take) begin
      out_red        <= sample ? PIX_WHITE : pixel_red;
      out_green      <= sample ? PIX_WHITE : pixel_green;
      out_blue       <= sample ? PIX_WHITE : pixel_blue;
      averages_valid <= 1'b0;
      average_red    <= '0;
      average_green  <= '0;
      average_blue   <= '0;
    end else if (cmd.div_done) begin
      averages_valid <= 1'b1;
      average_red    <= avg[0];
      average_green  <= avg[1];
      average_blue   <= avg[2];
    end
  end

endmodule

// ----- hw/rtl/roi_threshold_color_average.sv -----
// Top level: region-of-interest thresholded mean color over a pixel stream.
//
// Usage:
//   pix  - input pixels in raster order, valid/ready; last_pixel ends a frame.
//   res  - one result item per pixel: the pixel (white if sampled) and, on the
//          last pixel of a frame, averages_valid with the per-channel means.
//   cfg  - register writes (index, data), always ready; write only while idle.
// Flow and throughput:
//   An ordinary pixel appears on res in the cycle after it is taken, and one
//   pixel per cycle is sustained while res keeps up.
//   The last pixel of a frame runs the mean division: a setup step, eight
//   quotient-bit steps in three parallel shift-subtract units and a load
//   step; pix is not ready until its result is presented on res.
// Reset (rst, synchronous): registers go to their default window and
//   threshold, position and sums clear, the sample count starts at one.
// Stall: while a result waits on res, pix takes a new pixel only in the
//   cycle that result is taken.
`timescale 1ns / 1ps
module roi_threshold_color_average
  import rtca_pkg::*;
#(
  parameter int FRAME_WIDTH = DEFAULT_FRAME_WIDTH
) (
  input logic          clk,
  input logic          rst,
  rtca_pixel_if.sink   pix,
  rtca_result_if.source res,
  rtca_cfg_if.sink     cfg
);

  rtca_cmd_t    cmd;
  rtca_status_t status;

  assign cfg.ready = 1'b1;

  rtca_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pix.valid),
    .in_ready  (pix.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .status    (status),
    .cmd       (cmd)
  );

  rtca_datapath #(
    .FRAME_WIDTH (FRAME_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg.valid),
    .cfg_index      (cfg.index),
    .cfg_data       (cfg.data),
    .pixel_red      (pix.pixel_red),
    .pixel_green    (pix.pixel_green),
    .pixel_blue     (pix.pixel_blue),
    .last_pixel     (pix.last_pixel),
    .cmd            (cmd),
    .status         (status),
    .out_red        (res.out_red),
    .out_green      (res.out_green),
    .out_blue       (res.out_blue),
    .averages_valid (res.averages_valid),
    .average_red    (res.average_red),
    .average_green  (res.average_green),
    .average_blue   (res.average_blue)
  );

endmodule
